// ===== rtl/core/wblt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblt_pkg
// Shared types and codes for the write buffer latency tracker.
// ----------------------------------------------------------------------------
package wblt_pkg;

    localparam int ADDR_W = 48;
    localparam int TIME_W = 48;
    localparam int LAT_W  = 16;
    localparam int CNT_W  = 32;
    localparam int OCC_W  = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_ENTRIES_IN_USE = 2'd0;
    localparam logic [1:0] CFG_COALESCE       = 2'd1;
    localparam logic [1:0] CFG_BASE_LATENCY   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] done;
    } entry_t;

    typedef struct packed {
        logic shift;     // take the neighbor's entry
        logic load;      // take the fresh entry (wins over shift)
        logic occupied;  // slot holds a queued entry
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/wblt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wblt_cell
// One buffer slot: holds an entry, shifts toward the head, matches addresses.
// ----------------------------------------------------------------------------
module wblt_cell
(
    input  wire                          clk,
    input  wblt_pkg::cell_ctl_t          ctl,
    input  wblt_pkg::entry_t             neighbor,
    input  wblt_pkg::entry_t             fresh,
    input  wire  [wblt_pkg::ADDR_W-1:0]  query_addr,
    output wblt_pkg::entry_t             entry,
    output logic                         hit
);

    wblt_pkg::entry_t entry_reg;
    wblt_pkg::entry_t entry_next;

    always_comb
    begin
        priority if (ctl.load)
        begin
            entry_next = fresh;
        end
        else if (ctl.shift)
        begin
            entry_next = neighbor;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign hit   = ctl.occupied && (entry_reg.addr == query_addr);

endmodule
`default_nettype wire

// ===== rtl/core/write_buffer_latency_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// write_buffer_latency_tracker
// Coalescing write buffer timing model built as a shifting row of slots.
// ----------------------------------------------------------------------------
// Sequence: an accepted write first retires the completed entries at the head
//   (one retire step per cycle in the slot row), then sees the head is still
//   pending and moves to the decision step, which registers the result.
// Flow: a new write is taken only after the decision step is done; a stalled
//   receiver holding the previous result holds the decision step.
// Reset: rst_n clears fill count, counters and handshake state, and loads the
//   register defaults (8 entries, coalescing on, base_lat_reg = 1).
// ----------------------------------------------------------------------------
module write_buffer_latency_tracker
#(
    parameter int DEPTH = 8
)
(
    input  wire          clk,
    input  wire          rst_n,
    // configuration
    input  wire          cfg_wen,
    input  wire  [1:0]   cfg_index,
    input  wire  [15:0]  cfg_data,
    // write stream
    input  wire          s_tvalid,
    output logic         s_tready,
    // [47:0] write_address, [95:48] current_time, [111:96] drain_latency
    input  wire  [111:0] s_tdata,
    // result stream
    output logic         m_tvalid,
    input  wire          m_tready,
    // [47:0] write_latency, [51:48] occupancy, [83:52] insert_total,
    // [115:84] overflow_total, [147:116] access_total, [151:148] zero
    output logic [151:0] m_tdata,
    // [0] was_coalesced, [1] was_overflow
    output logic [1:0]   m_tuser
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > 4) ? CW : 4;
    localparam int AW = wblt_pkg::ADDR_W;
    localparam int TW = wblt_pkg::TIME_W;
    localparam int CNT = wblt_pkg::CNT_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [3:0]  entries_reg;
    logic        coalesce_reg;
    logic [15:0] base_lat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg  <= 4'd8;
            coalesce_reg <= 1'b1;
            base_lat_reg <= 16'd1;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                wblt_pkg::CFG_ENTRIES_IN_USE: entries_reg  <= cfg_data[3:0];
                wblt_pkg::CFG_COALESCE:       coalesce_reg <= cfg_data[0];
                wblt_pkg::CFG_BASE_LATENCY:   base_lat_reg <= cfg_data;
                default:                      ;  // write beyond the map: drop
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state and held input
    // ------------------------------------------------------------------
    wblt_pkg::state_t state_reg, state_next;

    logic [CW-1:0]   fill_reg, fill_next;
    logic [TW-1:0]   tail_reg, tail_next;   // completion time of the youngest entry
    logic [CNT-1:0]  ins_reg, ins_next;
    logic [CNT-1:0]  ovf_reg, ovf_next;
    logic [CNT-1:0]  acc_reg, acc_next;

    logic [AW-1:0]   addr_reg;
    logic [TW-1:0]   now_reg;
    logic [15:0]     drain_reg;

    logic            out_valid_reg, out_valid_next;
    logic [TW-1:0]   out_lat_reg;
    logic            out_merged_reg, out_ovf_reg;
    logic [3:0]      out_occ_reg;

    // slot row
    wblt_pkg::entry_t   cell_q [DEPTH];
    wblt_pkg::cell_ctl_t cell_ctl [DEPTH];
    logic [DEPTH-1:0]   hit_vec;
    wblt_pkg::entry_t   fresh;

    // decision signals
    logic            accept;
    logic            retire_step;
    logic            decide_fire;
    logic            merged;
    logic            full;
    logic [LW-1:0]   limit;
    logic [LW-1:0]   eiu_ext;
    logic [TW-1:0]   start_time;
    logic [TW:0]     done_sum;
    logic [TW-1:0]   new_done;
    logic [TW-1:0]   stall;
    logic [TW:0]     lat_sum;
    logic [TW-1:0]   lat_value;
    logic [CW-1:0]   load_pos;

    assign accept = s_tvalid && s_tready;

    // clamp the entry limit to 1..DEPTH
    assign eiu_ext = LW'(entries_reg);
    always_comb
    begin
        priority if (eiu_ext == '0)
        begin
            limit = LW'(1);
        end
        else if (eiu_ext > LW'(DEPTH))
        begin
            limit = LW'(DEPTH);
        end
        else
        begin
            limit = eiu_ext;
        end
    end

    assign merged = coalesce_reg && (|hit_vec);
    assign full   = LW'(fill_reg) >= limit;

    // start at the later of now and the tail's completion time
    assign start_time = ((fill_reg != '0) && (tail_reg > now_reg)) ? tail_reg : now_reg;
    assign done_sum   = {1'b0, start_time} + {{(TW - 15){1'b0}}, drain_reg};
    assign new_done   = done_sum[TW] ? {TW{1'b1}} : done_sum[TW-1:0];

    // stall charged by evicting the head
    assign stall     = (cell_q[0].done > now_reg) ? (cell_q[0].done - now_reg) : '0;
    assign lat_sum   = {{(TW - 15){1'b0}}, base_lat_reg}
                       + ((!merged && full) ? {1'b0, stall} : '0);
    assign lat_value = lat_sum[TW] ? {TW{1'b1}} : lat_sum[TW-1:0];

    assign load_pos = full ? (fill_reg - CW'(1)) : fill_reg;

    assign fresh.addr = addr_reg;
    assign fresh.done = new_done;

    // ------------------------------------------------------------------
    // sequencer: next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        tail_next      = tail_reg;
        ins_next       = ins_reg;
        ovf_next       = ovf_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        retire_step    = 1'b0;
        decide_fire    = 1'b0;

        unique case (state_reg)
            wblt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = wblt_pkg::ST_RETIRE;
                end
            end
            wblt_pkg::ST_RETIRE:
            begin
                // drop the head while it has completed; the queue is time-ordered
                if ((fill_reg != '0) && (now_reg >= cell_q[0].done))
                begin
                    retire_step = 1'b1;
                    fill_next   = fill_reg - CW'(1);
                end
                else
                begin
                    state_next = wblt_pkg::ST_DECIDE;
                end
            end
            wblt_pkg::ST_DECIDE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || m_tready)
                begin
                    decide_fire    = 1'b1;
                    out_valid_next = 1'b1;
                    acc_next       = acc_reg + CNT'(1);
                    state_next     = wblt_pkg::ST_IDLE;
                    if (!merged)
                    begin
                        ins_next  = ins_reg + CNT'(1);
                        tail_next = new_done;
                        if (full)
                        begin
                            ovf_next = ovf_reg + CNT'(1);
                        end
                        else
                        begin
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = wblt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wblt_pkg::ST_IDLE;
            fill_reg      <= '0;
            ins_reg       <= '0;
            ovf_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ins_reg       <= ins_next;
            ovf_reg       <= ovf_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: capture the write, the tail time and the result
    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        if (accept)
        begin
            addr_reg  <= s_tdata[47:0];
            now_reg   <= s_tdata[95:48];
            drain_reg <= s_tdata[111:96];
        end
        if (decide_fire)
        begin
            out_lat_reg    <= lat_value;
            out_merged_reg <= merged;
            out_ovf_reg    <= !merged && full;
            out_occ_reg    <= 4'(fill_next);
        end
    end

    // ------------------------------------------------------------------
    // slot row: every slot shifts on a retire or an eviction, one slot loads
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            wblt_pkg::entry_t neighbor;

            assign cell_ctl[gi].occupied = CW'(gi) < fill_reg;
            assign cell_ctl[gi].shift    = retire_step || (decide_fire && !merged && full);
            assign cell_ctl[gi].load     = decide_fire && !merged && (CW'(gi) == load_pos);

            if (gi < DEPTH - 1)
            begin : g_mid
                assign neighbor = cell_q[gi + 1];
            end
            else
            begin : g_last
                assign neighbor = fresh;
            end

            wblt_cell u_cell
            (
                .clk        (clk),
                .ctl        (cell_ctl[gi]),
                .neighbor   (neighbor),
                .fresh      (fresh),
                .query_addr (addr_reg),
                .entry      (cell_q[gi]),
                .hit        (hit_vec[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // result stream
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, acc_reg, ovf_reg, ins_reg, out_occ_reg, out_lat_reg};
    assign m_tuser  = {out_ovf_reg, out_merged_reg};

endmodule
`default_nettype wire
